[sv/olid_pkg.sv]
// Shared types and constants for the ordered list unit.
package olid_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int LEN_W        = 8;
    localparam int DEF_CAPACITY = 16;

    typedef enum logic [1:0] {
        KIND_INS  = 2'd0,
        KIND_DEL  = 2'd1,
        KIND_FIND = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_RANGE     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } t_cell_op;

    // Broadcast from the control logic to every cell of the row.
    typedef struct packed {
        t_cell_op                  op;
        logic [POS_W-1:0]          pos;
        logic signed [DATA_W-1:0]  value;
        logic [LEN_W-1:0]          len;
    } t_cell_ctl;

endpackage

[sv/olid_cell.sv]
// One list slot: holds a word, shifts to or from its neighbors and compares.
module olid_cell #(
    parameter int IDX = 0
) (
    input  logic                              i_clk,
    input  olid_pkg::t_cell_ctl               i_ctl,
    input  logic signed [olid_pkg::DATA_W-1:0] i_left,
    input  logic signed [olid_pkg::DATA_W-1:0] i_right,
    output logic signed [olid_pkg::DATA_W-1:0] o_data,
    output logic                              o_match
);
    import olid_pkg::*;

    localparam logic [POS_W-1:0] SLOT = POS_W'(IDX + 1);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_INS: begin
                if (SLOT == i_ctl.pos) begin
                    n_data = i_ctl.value;
                end else if (SLOT > i_ctl.pos) begin
                    n_data = i_left;
                end
            end
            CELL_DEL: begin
                if (SLOT >= i_ctl.pos) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Only slots below the current length hold list entries.
    assign o_match = (LEN_W'(IDX) < i_ctl.len) && (r_data == i_ctl.value);
    assign o_data  = r_data;

endmodule

[sv/ordered_list_insert_delete_find_unit.sv]
// Top level of the ordered list unit: control, cell row and result register.
//
// Keeps a packed list of up to CAPACITY signed 32-bit words in a row of cells.
// Operations arrive on the slave stream: tuser carries the kind (insert,
// delete, find) and tdata the position and the word. Each operation yields
// one result on the master stream with a status, the found position and the
// list length after the operation.
// Insert and delete move every affected cell one slot in the same cycle, and
// find compares all cells at once, so the list itself is updated in the
// transfer cycle. After that, the busy state resolves the first match with a
// priority encoder and loads the output register once that register is free
// or its result is taken; only then is a new operation accepted. The input
// side is not ready while the resolve is pending.
// A result waiting in the output register does not block the next input
// transfer; only a second finished result holds the unit until the first one
// is taken. Reset empties the list and drops any pending result.
module ordered_list_insert_delete_find_unit #(
    parameter int CAPACITY = olid_pkg::DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // position[7:0], value[39:8]
    input  logic [1:0]  i_s_tuser,  // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata   // status[1:0], found_position[9:2],
                                    // list_length[17:10], zero[23:18]
);
    import olid_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_busy;
    logic                 r_find;
    t_status              r_status;
    t_status              n_status;
    logic [CAPACITY-1:0]  r_match;
    logic                 r_out_valid;
    logic [17:0]          r_out;

    t_cell_ctl                ctl;
    logic                     s_xfer;
    logic [POS_W-1:0]         in_pos;
    logic signed [DATA_W-1:0] in_value;
    logic [POS_W:0]           len_ext;
    logic [CAPACITY-1:0]      match;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    logic                     hit;
    logic [IW-1:0]            hit_idx;
    t_status                  res_status;
    logic [LEN_W-1:0]         res_found;
    logic                     out_load;

    assign o_s_tready = !r_busy;
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign in_pos     = i_s_tdata[POS_W-1:0];
    assign in_value   = i_s_tdata[POS_W +: DATA_W];
    assign len_ext    = (POS_W+1)'(r_count);

    // Decode the operation and check its position against the list length.
    always_comb begin
        ctl.op    = CELL_HOLD;
        ctl.pos   = in_pos;
        ctl.value = in_value;
        ctl.len   = LEN_W'(r_count);
        n_count   = r_count;
        n_status  = ST_DONE;
        unique case (t_kind'(i_s_tuser))
            KIND_INS: begin
                if (in_pos == '0 || (POS_W+1)'(in_pos) > len_ext + 1'b1) begin
                    n_status = ST_RANGE;
                end else if (r_count == CW'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.op  = CELL_INS;
                    n_count = r_count + 1'b1;
                end
            end
            KIND_DEL: begin
                if (in_pos == '0 || (POS_W+1)'(in_pos) > len_ext) begin
                    n_status = ST_RANGE;
                end else begin
                    ctl.op  = CELL_DEL;
                    n_count = r_count - 1'b1;
                end
            end
            KIND_FIND: n_status = ST_NOT_FOUND;
            default:   n_status = ST_RANGE;
        endcase
        if (!s_xfer) begin
            ctl.op  = CELL_HOLD;
            n_count = r_count;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] right;
        if (g == 0) begin : g_first
            assign left = ctl.value;
        end else begin : g_mid
            assign left = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = cell_data[g];
        end else begin : g_inner
            assign right = cell_data[g+1];
        end
        olid_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[g]),
            .o_match (match[g])
        );
    end

    // The lowest matching slot wins.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
        end
        res_status = r_status;
        res_found  = '0;
        if (r_find && hit) begin
            res_status = ST_DONE;
            res_found  = LEN_W'(hit_idx) + 1'b1;
        end
    end

    assign out_load = r_busy && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (s_xfer) begin
                r_busy <= 1'b1;
            end else if (out_load) begin
                r_busy <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_find   <= (t_kind'(i_s_tuser) == KIND_FIND);
            r_status <= n_status;
            r_match  <= match;
        end
        if (out_load) begin
            r_out <= {LEN_W'(r_count), res_found, res_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out};

endmodule

[sv/olid_checker.sv]
// Port-level assertions for the ordered list unit and their bind.
module olid_checker #(
    parameter int CAPACITY = olid_pkg::DEF_CAPACITY
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [39:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);
    import olid_pkg::*;

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result pending after reset");

    // The list never reports more entries than it can hold.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[17:10] <= LEN_W'(CAPACITY)))
        else $error("list length beyond capacity");

    // A nonzero found position belongs only to a successful find.
    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[9:2] != '0) |->
            (o_m_tdata[1:0] == ST_DONE && o_m_tdata[9:2] <= o_m_tdata[17:10]))
        else $error("found position without a successful find");

    // Each operation is resolved before the next one is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken during resolve cycle");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind ordered_list_insert_delete_find_unit olid_checker #(
    .CAPACITY (CAPACITY)
) u_olid_checker (.*);
